// File: rtl/rbvi_pkg.sv
// Shared types for the rigid body velocity integrator.
// Holds the arithmetic unit's operation codes and request struct; no dependencies.
`timescale 1ns / 1ps

package rbvi_pkg;

    // Operand and result widths of the shared arithmetic unit
    localparam int WORD_W   = 64;
    localparam int MULT_A_W = 40;
    localparam int DIVR_W   = 32;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_req;

endpackage

// File: rtl/rigid_body_velocity_integrator_unit.sv
// Top level of the rigid body velocity integrator: APB registers, step sequencer, datapath.
// Depends on rbvi_pkg and instantiates the shared arithmetic unit rbvi_arith.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Contents
// ----------+-----------+---------------------------+-----------------------------------
// input     | in        | i_in_valid / o_in_ready   | force, step time, ground, position
// result    | out       | o_out_valid / i_out_ready | new position, new velocity
// config    | in        | psel / penable / pwrite   | six registers at byte address 4*i
//
// Every product, quotient and root of a step goes through one bit-serial unit, up to
// 24 products, 8 quotients and 3 roots per step, plus up to 30 normalising shifts.
// A new transfer is taken only when the sequencer is idle; a finished result waits
// in its output register while the next transfer is worked on.
// Synchronous active-low reset clears velocity and handshake state, sets register defaults.

module rigid_body_velocity_integrator_unit import rbvi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic [15:0]        i_step_time,
    input  logic               i_on_ground,
    input  logic signed [31:0] i_position_x,
    input  logic signed [31:0] i_position_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_new_position_x,
    output logic signed [31:0] o_new_position_y,
    output logic signed [31:0] o_new_velocity_x,
    output logic signed [31:0] o_new_velocity_y
);

    localparam int     FRAC_BITS = 16;
    localparam int     UNIT_BITS = 30;
    localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
    localparam longint MAX31     = 64'sh7FFF_FFFF;
    localparam longint GY_RAW    = -((680665 * ONE_Q) / 1000);

    localparam logic [15:0] MASS_RST     = 16'd256;
    localparam logic [30:0] FRICTION_RST = (100 * ONE_Q > MAX31) ? 31'h7FFF_FFFF
                                                                 : 31'(100 * ONE_Q);
    localparam logic [30:0] SIDE_RST     = (500 * ONE_Q > MAX31) ? 31'h7FFF_FFFF
                                                                 : 31'(500 * ONE_Q);
    localparam logic [30:0] FALL_RST     = (1000 * ONE_Q > MAX31) ? 31'h7FFF_FFFF
                                                                  : 31'(1000 * ONE_Q);
    localparam logic [31:0] GRAV_Y_RST   = (GY_RAW < -64'sd2147483648) ? 32'h8000_0000
                                                                       : 32'(GY_RAW);

    localparam logic [2:0] REG_MASS     = 3'd0;
    localparam logic [2:0] REG_FRICTION = 3'd1;
    localparam logic [2:0] REG_SIDE     = 3'd2;
    localparam logic [2:0] REG_FALL     = 3'd3;
    localparam logic [2:0] REG_GRAV_X   = 3'd4;
    localparam logic [2:0] REG_GRAV_Y   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    typedef enum logic [5:0] {
        ST_QX, ST_QXDT, ST_QY, ST_QYDT, ST_GX, ST_GY, ST_GINIT, ST_GNORM,
        ST_GXX, ST_GYY, ST_GLEN, ST_NX, ST_NY, ST_DOTX, ST_DOTY, ST_SXN,
        ST_SYN, ST_CLAMP, ST_AX, ST_AY, ST_MSX, ST_SXX, ST_SYY, ST_SLEN,
        ST_SCX, ST_SCXD, ST_SCY, ST_SCYD, ST_VSUM, ST_FR1, ST_FR2, ST_VXX,
        ST_VYY, ST_SPD, ST_KX, ST_KXD, ST_KY, ST_KYD, ST_PX, ST_PY
    } t_step;

    function automatic logic [63:0] f_mag(input logic signed [63:0] x);
        f_mag = x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > 64'sh7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < -64'sh8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        f_sat32 = res;
    endfunction

    // Control state
    t_state             r_state;
    t_step              r_step;
    t_step              n_step;
    logic               r_out_valid;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;

    // Configuration registers
    logic [15:0]        r_mass;
    logic [30:0]        r_friction;
    logic [30:0]        r_side;
    logic [30:0]        r_fall;
    logic signed [31:0] r_grav_x;
    logic signed [31:0] r_grav_y;

    // Transfer latches and working values
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;
    logic [15:0]        r_dt;
    logic               r_gnd;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_wx;
    logic signed [31:0] r_wy;
    logic signed [32:0] r_gx;
    logic signed [32:0] r_gy;
    logic signed [31:0] r_nx;
    logic signed [31:0] r_ny;
    logic signed [33:0] r_dot;
    logic signed [34:0] r_sx;
    logic signed [34:0] r_sy;
    logic signed [32:0] r_ax;
    logic signed [32:0] r_ay;
    logic [31:0]        r_msx;
    logic [31:0]        r_msy;
    logic [63:0]        r_t;
    logic [63:0]        r_u;
    logic [31:0]        r_len;
    logic [31:0]        r_keep;
    logic [38:0]        r_fr;
    logic               r_neg;

    // Output registers
    logic signed [31:0] r_o_px;
    logic signed [31:0] r_o_py;
    logic signed [31:0] r_o_vx;
    logic signed [31:0] r_o_vy;

    // Arithmetic unit request
    t_arith_req         w_req;
    logic [63:0]        u_a;
    logic [31:0]        u_b;
    logic               u_neg;
    logic               u_local;
    logic               w_done;
    logic [63:0]        w_res;

    logic               w_cfg_wr;
    logic               w_accept;
    logic [15:0]        w_m;

    logic signed [63:0] s_fx, s_fy, s_vx, s_vy, s_wx, s_wy, s_px, s_py;
    logic signed [63:0] s_gvx, s_gvy, s_gx, s_gy, s_nx, s_ny, s_dot, s_sx, s_sy;
    logic signed [63:0] s_ax, s_ay, s_t, s_fall, s_p, s_sxs, s_sys;
    logic [63:0]        mag_fx, mag_fy, mag_t, mag_gvx, mag_gvy, mag_gx, mag_gy;
    logic [63:0]        mag_wx, mag_wy, mag_nx, mag_ny, mag_dot, mag_sx, mag_sy;
    logic [63:0]        w_mg;
    logic [64:0]        w_sum65;
    logic [63:0]        w_sqsum;
    logic signed [31:0] n_wx;
    logic signed [31:0] n_wy;
    logic [31:0]        n_msx;
    logic [31:0]        n_msy;
    logic               w_gzero;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_m        = (r_mass == 16'd0) ? 16'd1 : r_mass;
    assign w_gzero    = (r_grav_x == 32'sd0) && (r_grav_y == 32'sd0);

    // Sign-extended views and magnitudes
    assign s_fx   = {{32{r_fx[31]}}, r_fx};
    assign s_fy   = {{32{r_fy[31]}}, r_fy};
    assign s_vx   = {{32{r_vx[31]}}, r_vx};
    assign s_vy   = {{32{r_vy[31]}}, r_vy};
    assign s_wx   = {{32{r_wx[31]}}, r_wx};
    assign s_wy   = {{32{r_wy[31]}}, r_wy};
    assign s_px   = {{32{r_px[31]}}, r_px};
    assign s_py   = {{32{r_py[31]}}, r_py};
    assign s_gvx  = {{32{r_grav_x[31]}}, r_grav_x};
    assign s_gvy  = {{32{r_grav_y[31]}}, r_grav_y};
    assign s_gx   = {{31{r_gx[32]}}, r_gx};
    assign s_gy   = {{31{r_gy[32]}}, r_gy};
    assign s_nx   = {{32{r_nx[31]}}, r_nx};
    assign s_ny   = {{32{r_ny[31]}}, r_ny};
    assign s_dot  = {{30{r_dot[33]}}, r_dot};
    assign s_sx   = {{29{r_sx[34]}}, r_sx};
    assign s_sy   = {{29{r_sy[34]}}, r_sy};
    assign s_ax   = {{31{r_ax[32]}}, r_ax};
    assign s_ay   = {{31{r_ay[32]}}, r_ay};
    assign s_t    = $signed(r_t);
    assign s_fall = {33'd0, r_fall};

    assign mag_fx  = f_mag(s_fx);
    assign mag_fy  = f_mag(s_fy);
    assign mag_t   = f_mag(s_t);
    assign mag_gvx = f_mag(s_gvx);
    assign mag_gvy = f_mag(s_gvy);
    assign mag_gx  = f_mag(s_gx);
    assign mag_gy  = f_mag(s_gy);
    assign mag_wx  = f_mag(s_wx);
    assign mag_wy  = f_mag(s_wy);
    assign mag_nx  = f_mag(s_nx);
    assign mag_ny  = f_mag(s_ny);
    assign mag_dot = f_mag(s_dot);
    assign mag_sx  = f_mag(s_sx);
    assign mag_sy  = f_mag(s_sy);
    assign w_mg    = (mag_gx > mag_gy) ? mag_gx : mag_gy;

    // Saturating sum of the two squares for the root
    assign w_sum65 = {1'b0, r_t} + {1'b0, r_u};
    assign w_sqsum = w_sum65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_sum65[63:0];

    // Signed result of the unit
    assign s_p = r_neg ? -$signed(w_res) : $signed(w_res);

    // Clamp side magnitudes and rebuild velocity from the two parts
    assign n_msx = (mag_sx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag_sx[31:0];
    assign n_msy = (mag_sy > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag_sy[31:0];
    assign s_sxs = r_sx[34] ? -$signed({32'd0, r_msx}) : $signed({32'd0, r_msx});
    assign s_sys = r_sy[34] ? -$signed({32'd0, r_msy}) : $signed({32'd0, r_msy});
    assign n_wx  = f_sat32(s_ax + s_sxs);
    assign n_wy  = f_sat32(s_ay + s_sys);

    // Operands for the current step
    always_comb begin
        u_a     = 64'd0;
        u_b     = 32'd0;
        u_neg   = 1'b0;
        u_local = 1'b0;
        w_req.op = OP_MUL;
        case (r_step)
            ST_QX:    begin w_req.op = OP_DIV; u_a = mag_fx << 8; u_b = {16'd0, w_m};
                            u_neg = r_fx[31]; end
            ST_QXDT:  begin u_a = mag_t; u_b = {16'd0, r_dt}; u_neg = r_t[63]; end
            ST_QY:    begin w_req.op = OP_DIV; u_a = mag_fy << 8; u_b = {16'd0, w_m};
                            u_neg = r_fy[31]; end
            ST_QYDT:  begin u_a = mag_t; u_b = {16'd0, r_dt}; u_neg = r_t[63]; end
            ST_GX:    begin u_a = mag_gvx; u_b = {16'd0, r_dt}; u_neg = r_grav_x[31]; end
            ST_GY:    begin u_a = mag_gvy; u_b = {16'd0, r_dt}; u_neg = r_grav_y[31]; end
            ST_GINIT: begin u_local = 1'b1; end
            ST_GNORM: begin u_local = 1'b1; end
            ST_GXX:   begin u_a = mag_gx; u_b = mag_gx[31:0]; end
            ST_GYY:   begin u_a = mag_gy; u_b = mag_gy[31:0]; end
            ST_GLEN:  begin w_req.op = OP_SQRT; u_a = w_sqsum; end
            ST_NX:    begin w_req.op = OP_DIV; u_a = mag_gx << UNIT_BITS; u_b = r_len;
                            u_neg = r_gx[32]; end
            ST_NY:    begin w_req.op = OP_DIV; u_a = mag_gy << UNIT_BITS; u_b = r_len;
                            u_neg = r_gy[32]; end
            ST_DOTX:  begin u_a = mag_wx; u_b = mag_nx[31:0]; u_neg = r_wx[31] ^ r_nx[31]; end
            ST_DOTY:  begin u_a = mag_wy; u_b = mag_ny[31:0]; u_neg = r_wy[31] ^ r_ny[31]; end
            ST_SXN:   begin u_a = mag_dot; u_b = mag_nx[31:0]; u_neg = r_dot[33] ^ r_nx[31]; end
            ST_SYN:   begin u_a = mag_dot; u_b = mag_ny[31:0]; u_neg = r_dot[33] ^ r_ny[31]; end
            ST_CLAMP: begin u_local = 1'b1; end
            ST_AX:    begin u_a = mag_dot; u_b = mag_nx[31:0]; u_neg = r_dot[33] ^ r_nx[31]; end
            ST_AY:    begin u_a = mag_dot; u_b = mag_ny[31:0]; u_neg = r_dot[33] ^ r_ny[31]; end
            ST_MSX:   begin u_local = 1'b1; end
            ST_SXX:   begin u_a = {32'd0, r_msx}; u_b = r_msx; end
            ST_SYY:   begin u_a = {32'd0, r_msy}; u_b = r_msy; end
            ST_SLEN:  begin w_req.op = OP_SQRT; u_a = w_sqsum; end
            ST_SCX:   begin u_a = {32'd0, r_msx}; u_b = {1'b0, r_side}; end
            ST_SCXD:  begin w_req.op = OP_DIV; u_a = r_t; u_b = r_len; end
            ST_SCY:   begin u_a = {32'd0, r_msy}; u_b = {1'b0, r_side}; end
            ST_SCYD:  begin w_req.op = OP_DIV; u_a = r_t; u_b = r_len; end
            ST_VSUM:  begin u_local = 1'b1; end
            ST_FR1:   begin u_a = {33'd0, r_friction}; u_b = {16'd0, w_m}; end
            ST_FR2:   begin u_a = r_t; u_b = {16'd0, r_dt}; end
            ST_VXX:   begin u_a = mag_wx; u_b = mag_wx[31:0]; end
            ST_VYY:   begin u_a = mag_wy; u_b = mag_wy[31:0]; end
            ST_SPD:   begin w_req.op = OP_SQRT; u_a = w_sqsum; end
            ST_KX:    begin u_a = mag_wx; u_b = r_keep; end
            ST_KXD:   begin w_req.op = OP_DIV; u_a = r_t; u_b = r_len; u_neg = r_wx[31]; end
            ST_KY:    begin u_a = mag_wy; u_b = r_keep; end
            ST_KYD:   begin w_req.op = OP_DIV; u_a = r_t; u_b = r_len; u_neg = r_wy[31]; end
            ST_PX:    begin u_a = mag_wx; u_b = {16'd0, r_dt}; u_neg = r_wx[31]; end
            ST_PY:    begin u_a = mag_wy; u_b = {16'd0, r_dt}; u_neg = r_wy[31]; end
            default:  begin u_local = 1'b1; end
        endcase
        w_req.start = (r_state == S_ISSUE) && !u_local;
    end

    // Next step, with the skips for ground, zero gravity, side clamp and friction
    always_comb begin
        n_step = t_step'(6'(r_step) + 6'd1);
        case (r_step)
            ST_QYDT:  n_step = r_gnd ? ST_GINIT : ST_GX;
            ST_GINIT: n_step = w_gzero ? ST_DOTX : ST_GNORM;
            ST_GNORM: n_step = (w_mg < (64'd1 << UNIT_BITS)) ? ST_GNORM : ST_GXX;
            ST_SLEN:  n_step = (w_res[31:0] > {1'b0, r_side}) ? ST_SCX : ST_VSUM;
            ST_VSUM:  n_step = ((n_wx == 32'sd0) && (n_wy == 32'sd0)) ? ST_PX : ST_FR1;
            ST_SPD:   n_step = ({7'd0, w_res[31:0]} <= r_fr) ? ST_PX : ST_KX;
            ST_PY:    n_step = ST_QX;
            default:  n_step = t_step'(6'(r_step) + 6'd1);
        endcase
    end

    rbvi_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (u_a),
        .i_b     (u_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // Sequencer, stored velocity, configuration writes and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_QX;
            r_out_valid <= 1'b0;
            r_vx        <= 32'sd0;
            r_vy        <= 32'sd0;
            r_mass      <= MASS_RST;
            r_friction  <= FRICTION_RST;
            r_side      <= SIDE_RST;
            r_fall      <= FALL_RST;
            r_grav_x    <= 32'sd0;
            r_grav_y    <= GRAV_Y_RST;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[4:2])
                    REG_MASS:     r_mass     <= pwdata[15:0];
                    REG_FRICTION: r_friction <= pwdata[30:0];
                    REG_SIDE:     r_side     <= pwdata[30:0];
                    REG_FALL:     r_fall     <= pwdata[30:0];
                    REG_GRAV_X:   r_grav_x   <= pwdata;
                    REG_GRAV_Y:   r_grav_y   <= pwdata;
                    default:      ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ISSUE;
                        r_step  <= ST_QX;
                    end
                end
                S_ISSUE: begin
                    if (u_local) begin
                        r_step <= n_step;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        if (r_step == ST_PY) begin
                            r_state <= S_OUT;
                            r_vx    <= r_wx;
                            r_vy    <= r_wy;
                        end else begin
                            r_state <= S_ISSUE;
                            r_step  <= n_step;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: latch the transfer, do local steps, collect unit results, load outputs
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fx  <= i_force_x;
            r_fy  <= i_force_y;
            r_dt  <= i_step_time;
            r_gnd <= i_on_ground;
            r_px  <= i_position_x;
            r_py  <= i_position_y;
        end
        if (w_req.start) begin
            r_neg <= u_neg;
        end
        if ((r_state == S_ISSUE) && u_local) begin
            case (r_step)
                ST_GINIT: begin
                    r_nx <= 32'sd0;
                    r_ny <= 32'sd0;
                    r_gx <= {r_grav_x[31], r_grav_x};
                    r_gy <= {r_grav_y[31], r_grav_y};
                end
                ST_GNORM: begin
                    if (w_mg < (64'd1 << UNIT_BITS)) begin
                        r_gx <= r_gx <<< 1;
                        r_gy <= r_gy <<< 1;
                    end
                end
                ST_CLAMP: begin
                    if (s_dot > s_fall) begin
                        r_dot <= 34'(s_fall);
                    end else if (s_dot < -s_fall) begin
                        r_dot <= 34'(-s_fall);
                    end
                end
                ST_MSX: begin
                    r_msx <= n_msx;
                    r_msy <= n_msy;
                end
                ST_VSUM: begin
                    r_wx <= n_wx;
                    r_wy <= n_wy;
                end
                default: ;
            endcase
        end
        if ((r_state == S_WAIT) && w_done) begin
            case (r_step)
                ST_QX, ST_QY, ST_DOTX: r_t <= s_p;
                ST_QXDT:  r_wx  <= f_sat32(s_vx + (s_p >>> 16));
                ST_QYDT:  r_wy  <= f_sat32(s_vy + (s_p >>> 16));
                ST_GX:    r_wx  <= f_sat32(s_wx + (s_p >>> 16));
                ST_GY:    r_wy  <= f_sat32(s_wy + (s_p >>> 16));
                ST_GXX, ST_SXX, ST_SCX, ST_VXX, ST_KX, ST_KY, ST_SCY: r_t <= w_res;
                ST_GYY, ST_SYY, ST_VYY: r_u <= w_res;
                ST_GLEN, ST_SLEN: r_len <= w_res[31:0];
                ST_NX:    r_nx  <= s_p[31:0];
                ST_NY:    r_ny  <= s_p[31:0];
                ST_DOTY:  r_dot <= r_gnd ? 34'sd0 : 34'((s_t + s_p) >>> UNIT_BITS);
                ST_SXN:   r_sx  <= 35'(s_wx - (s_p >>> UNIT_BITS));
                ST_SYN:   r_sy  <= 35'(s_wy - (s_p >>> UNIT_BITS));
                ST_AX:    r_ax  <= 33'(s_p >>> UNIT_BITS);
                ST_AY:    r_ay  <= 33'(s_p >>> UNIT_BITS);
                ST_SCXD:  r_msx <= w_res[31:0];
                ST_SCYD:  r_msy <= w_res[31:0];
                ST_FR1:   r_t   <= w_res >> 8;
                ST_FR2:   r_fr  <= 39'(w_res >> 16);
                ST_SPD: begin
                    r_len  <= w_res[31:0];
                    r_keep <= w_res[31:0] - r_fr[31:0];
                    if ({7'd0, w_res[31:0]} <= r_fr) begin
                        r_wx <= 32'sd0;
                        r_wy <= 32'sd0;
                    end
                end
                ST_KXD:   r_wx  <= s_p[31:0];
                ST_KYD:   r_wy  <= s_p[31:0];
                ST_PX:    r_px  <= f_sat32(s_px + (s_p >>> 16));
                ST_PY:    r_py  <= f_sat32(s_py + (s_p >>> 16));
                default: ;
            endcase
        end
        if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_o_px <= r_px;
            r_o_py <= r_py;
            r_o_vx <= r_wx;
            r_o_vy <= r_wy;
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            REG_MASS:     prdata = {16'd0, r_mass};
            REG_FRICTION: prdata = {1'b0, r_friction};
            REG_SIDE:     prdata = {1'b0, r_side};
            REG_FALL:     prdata = {1'b0, r_fall};
            REG_GRAV_X:   prdata = r_grav_x;
            REG_GRAV_Y:   prdata = r_grav_y;
            default:      prdata = 32'd0;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_new_position_x = r_o_px;
    assign o_new_position_y = r_o_py;
    assign o_new_velocity_x = r_o_vx;
    assign o_new_velocity_y = r_o_vy;

endmodule

// File: rtl/rbvi_arith.sv
// Shared bit-serial arithmetic unit: unsigned multiply, divide and square root.
// Depends on rbvi_pkg for the request struct and operation codes.
`timescale 1ns / 1ps

module rbvi_arith import rbvi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_arith_req           i_req,
    input  logic [WORD_W-1:0]    i_a,
    input  logic [DIVR_W-1:0]    i_b,
    output logic                 o_done,
    output logic [WORD_W-1:0]    o_res
);

    localparam logic [5:0] MUL_LAST  = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    logic            r_busy;
    logic            r_done;
    t_arith_op       r_op;
    logic [5:0]      r_cnt;
    logic [63:0]     r_a;
    logic [31:0]     r_b;
    logic [40:0]     r_r;
    logic [63:0]     r_q;

    logic [63:0]     n_a;
    logic [31:0]     n_b;
    logic [40:0]     n_r;
    logic [63:0]     n_q;
    logic [5:0]      w_last;

    logic [40:0]     w_msum;
    logic [32:0]     w_dt;
    logic            w_dge;
    logic [34:0]     w_st;
    logic [34:0]     w_trial;
    logic            w_sge;

    // One step of the selected operation
    always_comb begin
        w_msum  = r_r + (r_b[0] ? {1'b0, r_a[MULT_A_W-1:0]} : 41'd0);
        w_dt    = {r_r[31:0], r_a[63]};
        w_dge   = (w_dt >= {1'b0, r_b});
        w_st    = {r_r[32:0], r_a[63:62]};
        w_trial = {1'b0, r_q[31:0], 2'b01};
        w_sge   = (w_st >= w_trial);
        n_a     = r_a;
        n_b     = r_b;
        n_r     = r_r;
        n_q     = r_q;
        w_last  = MUL_LAST;
        case (r_op)
            OP_MUL: begin
                n_r    = {1'b0, w_msum[40:1]};
                n_b    = {w_msum[0], r_b[31:1]};
                w_last = MUL_LAST;
            end
            OP_DIV: begin
                n_r    = {8'd0, (w_dge ? (w_dt - {1'b0, r_b}) : w_dt)};
                n_a    = {r_a[62:0], 1'b0};
                n_q    = {r_q[62:0], w_dge};
                w_last = DIV_LAST;
            end
            OP_SQRT: begin
                n_r    = {6'd0, (w_sge ? (w_st - w_trial) : w_st)};
                n_a    = {r_a[61:0], 2'b00};
                n_q    = {r_q[62:0], w_sge};
                w_last = SQRT_LAST;
            end
            default: begin
                w_last = MUL_LAST;
            end
        endcase
    end

    // Sequence control: load on start, count iterations, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op <= i_req.op;
            r_a  <= i_a;
            r_b  <= i_b;
            r_r  <= 41'd0;
            r_q  <= 64'd0;
        end else if (r_busy) begin
            r_a <= n_a;
            r_b <= n_b;
            r_r <= n_r;
            r_q <= n_q;
        end
    end

    assign o_done = r_done;

    always_comb begin
        case (r_op)
            OP_MUL:  o_res = {r_r[31:0], r_b};
            OP_DIV:  o_res = r_q;
            OP_SQRT: o_res = {32'd0, r_q[31:0]};
            default: o_res = r_q;
        endcase
    end

endmodule
